[sv/sjis_pkg.sv]
package sjis_pkg;

  localparam int MaxBlocks  = 128;
  localparam int BlkAw      = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int BlkCw      = $clog2(MaxBlocks + 1);
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] ColumnsReset = 8'd9;
  localparam logic [7:0] RowsReset    = 8'd10;
  localparam logic [7:0] LineFeed     = 8'h0A;
  localparam logic [19:0] BaseOffset  = 20'd18;

  localparam logic [1:0] RegBlockCount = 2'd0;
  localparam logic [1:0] RegColumns    = 2'd1;
  localparam logic [1:0] RegRows       = 2'd2;

  typedef enum logic [1:0] {
    FUNC_TEXT  = 2'd0,
    FUNC_BLOCK = 2'd1,
    FUNC_START = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    JOB_PASS,
    JOB_WRITE,
    JOB_LOOKUP
  } job_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_ADDR
  } back_state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  text_byte;
    logic [6:0]  block_index;
    logic [15:0] block_first;
    logic [15:0] block_last;
  } in_item_t;

  typedef struct packed {
    logic        draw;
    logic [15:0] glyph_code;
    logic [19:0] glyph_address;
    logic [7:0]  column;
    logic [7:0]  row;
    logic        finished;
    logic [12:0] text_height;
  } out_item_t;

  // cursor state after the item
  typedef struct packed {
    logic [7:0]  column;
    logic [7:0]  row;
    logic        finished;
    logic [12:0] text_height;
  } status_t;

  typedef struct packed {
    job_e        op;
    logic [15:0] code;       // lookup code, or first code of a table write
    logic [15:0] code_last;
    logic [6:0]  index;
    logic [7:0]  draw_col;
    logic [7:0]  draw_row;
    status_t     status;
  } job_t;

  // partial half-width to full-width map, zero where unmapped
  function automatic logic [15:0] half_to_full(input logic [7:0] b);
    logic [15:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = 16'h824F + 16'(b - 8'h30);
    end else if (b inside {[8'h41:8'h5A]}) begin
      r = 16'h8260 + 16'(b - 8'h41);
    end else if (b inside {[8'h61:8'h7A]}) begin
      r = 16'h8281 + 16'(b - 8'h61);
    end else if (b inside {[8'hB1:8'hB5]}) begin
      r = 16'h8302 + (16'(b - 8'hB1) << 1);
    end else if (b inside {[8'hB6:8'hC1]}) begin
      r = 16'h834A + (16'(b - 8'hB6) << 1);
    end else if (b inside {[8'hC2:8'hC4]}) begin
      r = 16'h8363 + (16'(b - 8'hC2) << 1);
    end else if (b inside {[8'hC5:8'hC9]}) begin
      r = 16'h8369 + 16'(b - 8'hC5);
    end else if (b inside {[8'hCA:8'hCE]}) begin
      r = 16'h836E + 16'(b - 8'hCA) * 16'd3;
    end else if (b inside {[8'hCF:8'hD3]}) begin
      r = 16'h837D + 16'(b - 8'hCF);
    end
    return r;
  endfunction

endpackage

[sv/sjis_ram.sv]
module sjis_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/sjis_front.sv]
module sjis_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sjis_pkg::in_item_t in_data_i,
  input  logic [7:0]        columns_i,
  input  logic [7:0]        rows_i,
  input  logic              full_i,
  output logic              push_o,
  output sjis_pkg::job_t    job_o
);
  import sjis_pkg::*;

  logic       lead_waiting_q, lead_waiting_d;
  logic [7:0] lead_value_q, lead_value_d;
  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic       stopped_q, stopped_d;

  logic [7:0]  b;
  logic [15:0] c;
  logic        adv;
  logic        chk;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign b          = in_data_i.text_byte;

  always_comb begin
    lead_waiting_d = lead_waiting_q;
    lead_value_d   = lead_value_q;
    col_d          = col_q;
    row_d          = row_q;
    stopped_d      = stopped_q;
    c              = '0;
    adv            = 1'b0;
    chk            = 1'b1;

    job_o           = '0;
    job_o.op        = JOB_PASS;
    job_o.code      = in_data_i.block_first;
    job_o.code_last = in_data_i.block_last;
    job_o.index     = in_data_i.block_index;
    job_o.draw_col  = col_q;
    job_o.draw_row  = row_q;

    case (in_data_i.func)
      FUNC_BLOCK: begin
        job_o.op = JOB_WRITE;
      end
      FUNC_START: begin
        lead_waiting_d = 1'b0;
        lead_value_d   = '0;
        col_d          = '0;
        row_d          = '0;
        stopped_d      = 1'b0;
      end
      FUNC_TEXT: begin
        if (!stopped_q) begin
          if (lead_waiting_q) begin
            c              = {lead_value_q, b};
            lead_waiting_d = 1'b0;
            adv            = 1'b1;
          end else if (b inside {[8'h20:8'h7E], [8'hA1:8'hDF]}) begin
            c   = half_to_full(b);
            adv = 1'b1;
          end else if (b inside {[8'h81:8'h9F], [8'hE0:8'hFC]}) begin
            lead_waiting_d = 1'b1;
            lead_value_d   = b;
            chk            = 1'b0;
          end else if (b == LineFeed) begin
            col_d = '0;
            row_d = row_q + 8'd1;
          end
          if (adv) begin
            col_d = col_d + 8'd1;
            if (c != '0) begin
              job_o.op   = JOB_LOOKUP;
              job_o.code = c;
            end
          end
          if (chk) begin
            if (col_d >= columns_i) begin
              col_d = '0;
              row_d = row_d + 8'd1;
            end
            stopped_d = (row_d >= rows_i);
          end
        end
      end
      default: begin
      end
    endcase

    job_o.status.column      = col_d;
    job_o.status.row         = row_d;
    job_o.status.finished    = stopped_d;
    job_o.status.text_height = {9'({1'b0, row_d} + 9'd1), 4'b0000};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_waiting_q <= 1'b0;
      lead_value_q   <= '0;
      col_q          <= '0;
      row_q          <= '0;
      stopped_q      <= 1'b0;
    end else if (push_o) begin
      lead_waiting_q <= lead_waiting_d;
      lead_value_q   <= lead_value_d;
      col_q          <= col_d;
      row_q          <= row_d;
      stopped_q      <= stopped_d;
    end
  end

endmodule

[sv/sjis_queue.sv]
module sjis_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sjis_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sjis_pkg::job_t job_o
);
  import sjis_pkg::*;

  job_t               mem_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;

  assign full_o  = (count_q == (QueueAw + 1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[sv/sjis_back.sv]
module sjis_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sjis_pkg::job_t     job_i,
  output logic               pop_o,
  input  logic [7:0]         block_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sjis_pkg::out_item_t out_data_o
);
  import sjis_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [BlkCw-1:0] idx_q, n_q;
  logic [BlkCw-1:0] idx_next, n_eff;
  logic [16:0] cnt_q, off_q;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;
  logic        out_free;

  logic        ram_we;
  logic [BlkAw-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;
  logic [15:0] f_code, l_code;
  logic        hit;
  logic        load_job, scan_step, take_hit;

  assign n_eff = (int'(block_count_i) > MaxBlocks) ? BlkCw'(MaxBlocks) : BlkCw'(block_count_i);
  assign idx_next  = idx_q + 1'b1;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign f_code    = ram_rdata[31:16];
  assign l_code    = ram_rdata[15:0];
  assign hit       = (f_code <= job_q.code) && (l_code >= job_q.code);
  assign ram_waddr = BlkAw'(job_i.index);
  assign ram_raddr = (state_q == B_IDLE) ? '0 : idx_next[BlkAw-1:0];

  sjis_ram #(
    .Width(32),
    .Depth(MaxBlocks)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({job_i.code, job_i.code_last}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    load_job    = 1'b0;
    scan_step   = 1'b0;
    take_hit    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      B_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o               = 1'b1;
          out_d.draw          = 1'b0;
          out_d.glyph_code    = '0;
          out_d.glyph_address = '0;
          out_d.column        = job_i.status.column;
          out_d.row           = job_i.status.row;
          out_d.finished      = job_i.status.finished;
          out_d.text_height   = job_i.status.text_height;
          if (job_i.op == JOB_LOOKUP && n_eff != '0) begin
            load_job = 1'b1;
            state_d  = B_SCAN;
          end else begin
            out_valid_d = 1'b1;
            ram_we      = (job_i.op == JOB_WRITE) && (int'(job_i.index) < MaxBlocks);
          end
        end
      end
      B_SCAN: begin
        if (hit) begin
          take_hit = 1'b1;
          state_d  = B_ADDR;
        end else if (idx_next == n_q) begin
          // code lies in no block: report the cursor only
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end else begin
          scan_step = 1'b1;
        end
      end
      B_ADDR: begin
        out_valid_d         = 1'b1;
        out_d.draw          = 1'b1;
        out_d.glyph_code    = job_q.code;
        out_d.glyph_address = ({12'd0, n_q} << 2) + BaseOffset + {off_q, 3'b000};
        out_d.column        = job_q.draw_col;
        out_d.row           = job_q.draw_row;
        state_d             = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load_job) begin
      job_q <= job_i;
      n_q   <= n_eff;
      idx_q <= '0;
      cnt_q <= '0;
    end
    if (scan_step) begin
      idx_q <= idx_next;
      // inverted blocks still add their size, modulo the address range
      cnt_q <= cnt_q + 17'(l_code) + 17'd1 - 17'(f_code);
    end
    if (take_hit) begin
      off_q <= 17'(job_q.code) - 17'(f_code) + cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_addr_gives_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_ADDR |=> out_valid_q && out_q.draw)
    else $error("glyph address state did not load a drawn result");

  a_walk_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_IDLE |-> !out_valid_q)
    else $error("table walk running while a result waits");

  a_no_pop_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != B_IDLE |-> !pop_o && !ram_we)
    else $error("queue popped or table written during a walk");

  a_draw_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.draw |-> out_q.glyph_code != 16'd0)
    else $error("drawn result carries a null code");
`endif

endmodule

[sv/sjis_text_to_glyph_address.sv]
// A transfer that needs no table walk passes through the queue and then the result register.
// A drawn code walks the block table, one RAM read per entry, before its result is registered.
// Throughput: one item per cycle on input while the 4-entry queue has room; the back end
// takes no new item from the queue while a lookup walks the table or a result is stalled.
// Reset (rst_ni, asynchronous, active low) clears the cursor, the queue and the result slot,
// sets block_count 0, columns 9, rows 10; block table entries are undefined until written.
module sjis_text_to_glyph_address (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sjis_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sjis_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sjis_pkg::*;

  logic [7:0] block_count_q, columns_q, rows_q;
  logic       cfg_write;
  logic       q_push, q_pop, q_full, q_empty;
  job_t       push_job, head_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      columns_q     <= ColumnsReset;
      rows_q        <= RowsReset;
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegBlockCount: block_count_q <= pwdata[7:0];
        RegColumns:    columns_q     <= pwdata[7:0];
        RegRows:       rows_q        <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBlockCount: prdata = {24'd0, block_count_q};
      RegColumns:    prdata = {24'd0, columns_q};
      RegRows:       prdata = {24'd0, rows_q};
      default:       prdata = '0;
    endcase
  end

  sjis_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .columns_i (columns_q),
    .rows_i    (rows_q),
    .full_i    (q_full),
    .push_o    (q_push),
    .job_o     (push_job)
  );

  sjis_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .job_o  (head_job)
  );

  sjis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .job_i        (head_job),
    .pop_o        (q_pop),
    .block_count_i(block_count_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sjis_pkg::*;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  sjis_text_to_glyph_address u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  in_item_t  byte_stream[$];
  out_item_t expected_glyphs[$];
  int        glyph_errors = 0;
  bit        steady = 1'b0;

  // predictor copy of the block's registers and cursor
  logic [7:0]  cfg_blocks = 8'd0;
  logic [7:0]  cfg_cols   = ColumnsReset;
  logic [7:0]  cfg_rows   = RowsReset;
  bit          lead_held  = 1'b0;
  logic [7:0]  lead_byte  = 8'd0;
  logic [7:0]  cur_col    = 8'd0;
  logic [7:0]  cur_row    = 8'd0;
  bit          halted     = 1'b0;
  logic [15:0] glyph_first [MaxBlocks];
  logic [15:0] glyph_last  [MaxBlocks];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] fullwidth_of(logic [7:0] b);
    logic [15:0] k;
    k = {8'h00, b};
    if (b >= 8'h30 && b <= 8'h39) return 16'h824F + k - 16'h30;
    if (b >= 8'h41 && b <= 8'h5A) return 16'h8260 + k - 16'h41;
    if (b >= 8'h61 && b <= 8'h7A) return 16'h8281 + k - 16'h61;
    if (b >= 8'hB1 && b <= 8'hB5) return 16'h8302 + (k - 16'hB1) * 2;
    if (b >= 8'hB6 && b <= 8'hC1) return 16'h834A + (k - 16'hB6) * 2;
    if (b >= 8'hC2 && b <= 8'hC4) return 16'h8363 + (k - 16'hC2) * 2;
    if (b >= 8'hC5 && b <= 8'hC9) return 16'h8369 + k - 16'hC5;
    if (b >= 8'hCA && b <= 8'hCE) return 16'h836E + (k - 16'hCA) * 3;
    if (b >= 8'hCF && b <= 8'hD3) return 16'h837D + k - 16'hCF;
    return 16'h0000;
  endfunction

  // inverted blocks never match but their size still counts, mod 2^32
  function automatic bit locate_glyph(logic [15:0] code, output logic [31:0] addr);
    int          n;
    logic [31:0] base, run, f, l;
    n    = (cfg_blocks > MaxBlocks) ? MaxBlocks : int'(cfg_blocks);
    base = 32'(n) * 4 + 32'(BaseOffset);
    run  = '0;
    addr = '0;
    for (int i = 0; i < n; i++) begin
      f = 32'(glyph_first[i]);
      l = 32'(glyph_last[i]);
      if (f <= 32'(code) && l >= 32'(code)) begin
        addr = (base + (32'(code) - f + run) * 8) & 32'hFFFFF;
        return 1'b1;
      end
      run = run + l + 1 - f;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t render_step(in_item_t it);
    out_item_t   r;
    logic [15:0] code;
    logic [31:0] addr;
    logic [7:0]  b;
    bit          adv, chk;
    r    = '0;
    code = '0;
    addr = '0;
    adv  = 1'b0;
    chk  = 1'b1;
    b    = it.text_byte;
    case (it.func)
      FUNC_BLOCK: begin
        glyph_first[it.block_index] = it.block_first;
        glyph_last[it.block_index]  = it.block_last;
      end
      FUNC_START: begin
        lead_held = 1'b0;
        lead_byte = 8'd0;
        cur_col   = 8'd0;
        cur_row   = 8'd0;
        halted    = 1'b0;
      end
      FUNC_TEXT: begin
        if (!halted) begin
          if (lead_held) begin
            code      = {lead_byte, b};
            lead_held = 1'b0;
            adv       = 1'b1;
          end else if ((b >= 8'h20 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hDF)) begin
            code = fullwidth_of(b);
            adv  = 1'b1;
          end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
            lead_held = 1'b1;
            lead_byte = b;
            chk       = 1'b0;
          end else if (b == LineFeed) begin
            cur_col = 8'd0;
            cur_row = cur_row + 8'd1;
          end
          if (adv) begin
            if (code != 16'h0000 && locate_glyph(code, addr)) begin
              r.draw          = 1'b1;
              r.glyph_code    = code;
              r.glyph_address = addr[19:0];
              r.column        = cur_col;
              r.row           = cur_row;
            end
            cur_col = cur_col + 8'd1;
          end
          if (chk) begin
            if (cur_col >= cfg_cols) begin
              cur_col = 8'd0;
              cur_row = cur_row + 8'd1;
            end
            if (cur_row >= cfg_rows) halted = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (!r.draw) begin
      r.column = cur_col;
      r.row    = cur_row;
    end
    r.finished    = halted;
    r.text_height = 13'((32'(cur_row) + 32'd1) * 32'd16);
    return r;
  endfunction

  function automatic void field_check(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      glyph_errors++;
      if (glyph_errors <= 10) begin
        $display("%0t: %s expected %h, got %h", $time, label, want, got);
      end
    end
  endfunction

  function automatic void check_glyph(out_item_t got);
    out_item_t want;
    if (expected_glyphs.size() == 0) begin
      glyph_errors++;
      if (glyph_errors <= 10) $display("%0t: result %h with nothing expected", $time, got);
      return;
    end
    want = expected_glyphs.pop_front();
    field_check("draw", 32'(want.draw), 32'(got.draw));
    field_check("glyph_code", 32'(want.glyph_code), 32'(got.glyph_code));
    field_check("glyph_address", 32'(want.glyph_address), 32'(got.glyph_address));
    field_check("column", 32'(want.column), 32'(got.column));
    field_check("row", 32'(want.row), 32'(got.row));
    field_check("finished", 32'(want.finished), 32'(got.finished));
    field_check("text_height", 32'(want.text_height), 32'(got.text_height));
  endfunction

  // driver: payload held while stalled, expectation formed on transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_glyphs.push_back(render_step(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (byte_stream.size() != 0 && (steady || $urandom_range(99, 0) >= 32)) begin
          in_data_i  <= byte_stream.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_glyph(out_data_o);
      out_stall_i <= !steady && ($urandom_range(99, 0) < 32);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegBlockCount: cfg_blocks = value;
      RegColumns:    cfg_cols   = value;
      RegRows:       cfg_rows   = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [7:0] blocks, logic [7:0] cols, logic [7:0] nrows);
    write_reg(RegBlockCount, blocks);
    write_reg(RegColumns, cols);
    write_reg(RegRows, nrows);
  endtask

  // wait until every transfer has been sent and its result has come back;
  // sampled on the falling edge so the driver's updates have landed
  task automatic settle();
    do begin
      @(negedge clk_i);
    end while (byte_stream.size() != 0 || in_valid_i || expected_glyphs.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_lead();
    if ($urandom_range(1, 0) != 0) return 8'($urandom_range(8'h9F, 8'h81));
    return 8'($urandom_range(8'hFC, 8'hE0));
  endfunction

  function automatic in_item_t block_entry(logic [6:0] idx);
    in_item_t    it;
    logic [15:0] a;
    logic [7:0]  lead;
    it             = '0;
    it.func        = FUNC_BLOCK;
    it.block_index = idx;
    it.text_byte   = 8'($urandom);
    case ($urandom_range(9, 0))
      0, 1: begin
        it.block_first = 16'($urandom);
        it.block_last  = 16'($urandom);
      end
      2: begin
        a              = 16'($urandom_range(16'hFFFF, 1));
        it.block_first = a;
        it.block_last  = 16'($urandom_range(32'(a) - 1, 0));
      end
      3, 4, 5: begin
        lead           = pick_lead();
        it.block_first = {lead, 8'h40};
        it.block_last  = {lead, 8'hFC};
      end
      default: begin
        it.block_first = 16'h8240 + 16'($urandom_range(16'h160, 0));
        it.block_last  = it.block_first + 16'($urandom_range(16'h40, 0));
      end
    endcase
    return it;
  endfunction

  function automatic logic [7:0] pick_halfwidth();
    if ($urandom_range(9, 0) < 3) begin
      if ($urandom_range(1, 0) != 0) return 8'($urandom_range(8'h7E, 8'h20));
      return 8'($urandom_range(8'hDF, 8'hA1));
    end
    case ($urandom_range(3, 0))
      0:       return 8'($urandom_range(8'h39, 8'h30));
      1:       return 8'($urandom_range(8'h5A, 8'h41));
      2:       return 8'($urandom_range(8'h7A, 8'h61));
      default: return 8'($urandom_range(8'hD3, 8'hB1));
    endcase
  endfunction

  task automatic push_text(logic [7:0] b);
    in_item_t it;
    it           = '0;
    it.func      = FUNC_TEXT;
    it.text_byte = b;
    byte_stream.push_back(it);
  endtask

  task automatic push_cmd(func_e f);
    in_item_t it;
    it      = '0;
    it.func = f;
    byte_stream.push_back(it);
  endtask

  task automatic push_block(logic [6:0] idx, logic [15:0] first, logic [15:0] last);
    in_item_t it;
    it             = '0;
    it.func        = FUNC_BLOCK;
    it.block_index = idx;
    it.block_first = first;
    it.block_last  = last;
    byte_stream.push_back(it);
  endtask

  // mostly well-formed text, with restarts, table rewrites and noise mixed in
  task automatic queue_text(int count);
    in_item_t it;
    int       roll;
    for (int k = 0; k < count; k++) begin
      it             = '0;
      it.block_index = 7'($urandom);
      it.block_first = 16'($urandom);
      it.block_last  = 16'($urandom);
      roll           = $urandom_range(99, 0);
      if (roll < 6) begin
        it.func = FUNC_START;
      end else if (roll < 9) begin
        it.func = FUNC_NONE;
      end else if (roll < 15) begin
        it = block_entry(7'($urandom));
      end else begin
        it.func = FUNC_TEXT;
        if (roll < 50) begin
          it.text_byte = pick_halfwidth();
        end else if (roll < 85) begin
          it.text_byte = pick_lead();
          byte_stream.push_back(it);
          it.text_byte = ($urandom_range(9, 0) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(8'hFC, 8'h40));
        end else if (roll < 92) begin
          it.text_byte = LineFeed;
        end else begin
          it.text_byte = 8'($urandom);
        end
      end
      byte_stream.push_back(it);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no blocks yet: cursor movement only, nothing drawn
    push_text(8'h41);
    push_text(8'h82);
    push_text(8'h60);
    push_text(LineFeed);
    push_text(8'h00);
    push_text(8'hFF);
    push_text(8'h80);
    push_text(8'hA0);
    push_cmd(FUNC_NONE);
    push_text(8'hE0);
    push_cmd(FUNC_START);

    // whole table written before any lookup can read it
    push_block(7'd0, 16'h8140, 16'h84BE);
    push_block(7'd1, 16'h889F, 16'h9872);
    push_block(7'd2, 16'h9000, 16'h8000);
    push_block(7'd3, 16'h0000, 16'hFFFF);
    for (int i = 4; i < MaxBlocks; i++) byte_stream.push_back(block_entry(7'(i)));
    settle();

    configure(8'd4, ColumnsReset, RowsReset);
    push_text(8'h30);
    push_text(8'h7A);
    push_text(8'hB1);
    push_text(8'hD3);
    push_text(8'hDF);
    push_text(8'h20);
    push_text(8'h88);
    push_text(8'h9F);
    push_text(8'hFC);
    push_text(8'hFC);
    push_text(8'h81);
    push_text(8'h00);
    push_text(LineFeed);
    settle();

    // a code outside the first two blocks is not drawn
    configure(8'd2, ColumnsReset, RowsReset);
    push_text(8'hE0);
    push_text(8'h40);

    for (int p = 0; p < 9; p++) begin
      settle();
      case (p)
        0:       configure(8'd128, ColumnsReset, RowsReset);
        1:       configure(8'd0, 8'd255, 8'd255);
        2:       configure(8'd1, 8'd1, 8'd1);
        3:       configure(8'd128, 8'd0, 8'd3);
        4:       configure(8'd2, 8'd5, 8'd0);
        5:       configure(8'd128, 8'd255, 8'd1);
        default: configure(8'($urandom_range(128, 0)), 8'($urandom_range(40, 1)),
                           8'($urandom_range(20, 1)));
      endcase
      steady = (p == 0);
      queue_text((p == 0) ? 50 : 32);
    end

    settle();
    repeat (300) @(posedge clk_i);
    if (glyph_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
